FILE: sv/shp3_pkg.sv
// shared types, register codes and helpers for the 3x3 sharpen stream
`default_nettype none

package shp3_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  // reset values of the configuration registers
  localparam logic [11:0] RESET_IMAGE_WIDTH   = 12'd640;
  localparam logic [15:0] RESET_IMAGE_HEIGHT  = 16'd480;
  localparam logic [2:0]  RESET_CHANNEL_COUNT = 3'd3;

  // result queue between the compute stage and the output port
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // history of centre samples, one per interleaved channel
  localparam int HIST_DEPTH = 4;

  // reciprocal for division by three: (2^17 + 1) / 3
  localparam logic [16:0] DIV3_RECIP = 17'd43691;
  localparam int          DIV3_SHIFT = 17;

  // classified word handed from the front to the compute stage
  typedef struct packed {
    logic [7:0] sample;
    logic       emit;
    logic       interior;
    logic       last;
    logic [1:0] chan_sel;
  } item_t;

  // one result word
  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } result_t;

  // pixel column of a sample position, channel count 1..4
  function automatic logic [15:0] div_by_chan(input logic [15:0] num,
                                               input logic [2:0]  chans);
    logic [32:0] prod;
    logic [15:0] quot;
    prod = 33'(num) * 33'(DIV3_RECIP);
    case (chans)
      3'd1: begin
        quot = num;
      end
      3'd2: begin
        quot = num >> 1;
      end
      3'd3: begin
        quot = 16'(prod >> DIV3_SHIFT);
      end
      default: begin
        quot = num >> 2;
      end
    endcase
    return quot;
  endfunction

endpackage

`default_nettype wire

FILE: sv/shp3_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module shp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/shp3_front.sv
// front end: config registers, raster counters, classification, line store access
`default_nettype none

module shp3_front #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4,
  localparam int PW          = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  // input stream
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [7:0]           sample,
  // line store access
  output logic                      newer_wr_en,
  output logic      [PW-1:0]        newer_wr_addr,
  output logic      [7:0]           newer_wr_data,
  output logic      [PW-1:0]        centre_rd_addr,
  output logic      [PW-1:0]        right_rd_addr,
  // classified word to the compute stage
  output logic                      item_valid,
  output shp3_pkg::item_t           item,
  output logic      [PW-1:0]        item_addr
);

  import shp3_pkg::*;

  localparam int LW = $clog2(MAX_WIDTH * MAX_CHANNELS + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [11:0]   image_width;
  logic [15:0]   image_height;
  logic [2:0]    channel_count;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [15:0]   row;
  logic [15:0]   row_next;

  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic [2:0]    eff_c;
  logic [LW-1:0] row_len;
  logic [LW-1:0] last_pos;
  logic [15:0]   col;
  logic          accept;
  logic          row_end;
  logic          last_row;
  logic          interior;

  assign accept = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RESET_IMAGE_WIDTH;
      image_height  <= RESET_IMAGE_HEIGHT;
      channel_count <= RESET_CHANNEL_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[11:0];
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
        end
        REG_CHANNEL_COUNT: begin
          channel_count <= cfg_data[2:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective geometry, saturated into the supported range
  always_comb begin
    if (image_width < 12'd3) begin
      eff_w = WW'(3);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height < 16'd3) begin
      eff_h = 16'd3;
    end else begin
      eff_h = image_height;
    end
    if (channel_count == 3'd0) begin
      eff_c = 3'd1;
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      eff_c = 3'(MAX_CHANNELS);
    end else begin
      eff_c = channel_count;
    end
  end

  // position classification
  assign row_len  = LW'(32'(eff_w) * 32'(eff_c));
  assign last_pos = row_len - LW'(1);
  assign row_end  = LW'(pos) >= last_pos;
  assign last_row = row >= (eff_h - 16'd1);
  assign col      = div_by_chan(16'(pos), eff_c);
  assign interior = (row >= 16'd2) && (col != 16'd0) && (col <= (16'(eff_w) - 16'd2));

  // raster counters
  always_comb begin
    pos_next = pos;
    row_next = row;
    if (accept) begin
      if (row_end) begin
        pos_next = '0;
        row_next = last_row ? 16'd0 : row + 16'd1;
      end else begin
        pos_next = pos + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      row        <= '0;
      item_valid <= 1'b0;
    end else begin
      pos        <= pos_next;
      row        <= row_next;
      item_valid <= accept;
    end
  end

  // classified word, read data arrives with it
  always_ff @(posedge clk) begin
    if (accept) begin
      item.sample   <= sample;
      item.emit     <= row != 16'd0;
      item.interior <= interior;
      item.last     <= last_row && row_end;
      item.chan_sel <= 2'(eff_c - 3'd1);
      item_addr     <= pos;
    end
  end

  // line store addresses: centre and up at the position, right one pixel on
  assign newer_wr_en    = accept;
  assign newer_wr_addr  = pos;
  assign newer_wr_data  = sample;
  assign centre_rd_addr = pos;
  assign right_rd_addr  = PW'(32'(pos) + 32'(eff_c));

endmodule

`default_nettype wire

FILE: sv/shp3_core.sv
// compute stage: 5-point laplacian sharpen, clamp, older line store update
`default_nettype none

module shp3_core #(
  parameter int PW = 13
) (
  input  wire logic            clk,
  input  wire logic            item_valid,
  input  wire shp3_pkg::item_t item,
  input  wire logic [PW-1:0]   item_addr,
  // line store read data for this word
  input  wire logic [7:0]      centre,
  input  wire logic [7:0]      right,
  input  wire logic [7:0]      up,
  // older line store write
  output logic                 older_wr_en,
  output logic      [PW-1:0]   older_wr_addr,
  output logic      [7:0]      older_wr_data,
  // result word to the queue
  output logic                 push,
  output shp3_pkg::result_t    push_data
);

  import shp3_pkg::*;

  logic [7:0]         hist [HIST_DEPTH];
  logic [7:0]         left;
  logic signed [11:0] acc;
  logic [7:0]         clamped;

  // recent centre samples; one pixel back is the left neighbour
  always_ff @(posedge clk) begin
    if (item_valid) begin
      hist[0] <= centre;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  assign left = hist[item.chan_sel];

  // 5*centre minus the four neighbours
  always_comb begin
    acc = $signed({2'b00, centre, 2'b00}) + $signed({4'b0000, centre})
        - $signed({4'b0000, left}) - $signed({4'b0000, right})
        - $signed({4'b0000, up}) - $signed({4'b0000, item.sample});
    if (acc < 12'sd0) begin
      clamped = 8'd0;
    end else if (acc > 12'sd255) begin
      clamped = 8'd255;
    end else begin
      clamped = acc[7:0];
    end
  end

  // centre moves into the older store
  assign older_wr_en   = item_valid;
  assign older_wr_addr = item_addr;
  assign older_wr_data = centre;

  assign push            = item_valid && item.emit;
  assign push_data.pixel = item.interior ? clamped : 8'd0;
  assign push_data.last  = item.last;

endmodule

`default_nettype wire

FILE: sv/shp3_queue.sv
// small result queue in front of the output port
`default_nettype none

module shp3_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire shp3_pkg::result_t         push_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output shp3_pkg::result_t              head,
  output logic [shp3_pkg::QCNT_W-1:0]    count
);

  import shp3_pkg::*;

  result_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10: begin
          count <= count + QCNT_W'(1);
        end
        2'b01: begin
          count <= count - QCNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/sharpen_3x3_stream.sv
// top level of the streaming 3x3 laplacian sharpen
//
// Input channel: one 8-bit channel byte per word on sample, interleaved
// pixels in raster order, moved when in_valid is high and in_stall low.
// Output channel: pixel_out and frame_last, moved when out_valid is high
// and out_stall low. Each word of row r (r >= 1) yields the result for
// row r-1 at the same position; row 0 yields nothing, border pixels are
// zero, and frame_last marks the result of the final word of the frame.
// Configuration: cfg_index 0 width, 1 height, 2 channel count, written
// with cfg_valid; cfg_ready is always high. Write while no word is in
// flight; out-of-range values are saturated.
// A taken word is registered as a classified word, and its result is written into the queue before it is offered.
// Throughput: one word per clock while in_stall is low, limited by the one
// write and one read port per line store each cycle.
// Reset: counters return to the top left corner, registers to 640 x 480
// x 3; the line stores need no clearing pass.
// Stall: a four-word queue holds results; in_stall rises while the queue
// plus the word in the compute stage fills it.
`default_nettype none

module sharpen_3x3_stream #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  sample,
  // output stream
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       pixel_out,
  output logic             frame_last
);

  import shp3_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int PW          = $clog2(STORE_DEPTH);

  logic              newer_wr_en;
  logic [PW-1:0]     newer_wr_addr;
  logic [7:0]        newer_wr_data;
  logic [PW-1:0]     centre_rd_addr;
  logic [PW-1:0]     right_rd_addr;
  logic              older_wr_en;
  logic [PW-1:0]     older_wr_addr;
  logic [7:0]        older_wr_data;
  logic [7:0]        centre;
  logic [7:0]        right;
  logic [7:0]        up;
  logic              item_valid;
  item_t             item;
  logic [PW-1:0]     item_addr;
  logic              push;
  result_t           push_data;
  result_t           head;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  // hold off input while queued plus in-flight words fill the queue
  assign in_stall = ({1'b0, q_count} + {{QCNT_W{1'b0}}, item_valid})
                    >= (QCNT_W+1)'(QUEUE_DEPTH);

  // classification and counters
  shp3_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .newer_wr_en    (newer_wr_en),
    .newer_wr_addr  (newer_wr_addr),
    .newer_wr_data  (newer_wr_data),
    .centre_rd_addr (centre_rd_addr),
    .right_rd_addr  (right_rd_addr),
    .item_valid     (item_valid),
    .item           (item),
    .item_addr      (item_addr)
  );

  // newer line store, one copy per read address
  shp3_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_newer_centre (
    .clk     (clk),
    .wr_en   (newer_wr_en),
    .wr_addr (newer_wr_addr),
    .wr_data (newer_wr_data),
    .rd_addr (centre_rd_addr),
    .rd_data (centre)
  );

  shp3_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_newer_right (
    .clk     (clk),
    .wr_en   (newer_wr_en),
    .wr_addr (newer_wr_addr),
    .wr_data (newer_wr_data),
    .rd_addr (right_rd_addr),
    .rd_data (right)
  );

  // older line store
  shp3_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_older (
    .clk     (clk),
    .wr_en   (older_wr_en),
    .wr_addr (older_wr_addr),
    .wr_data (older_wr_data),
    .rd_addr (centre_rd_addr),
    .rd_data (up)
  );

  // sharpen arithmetic
  shp3_core #(
    .PW (PW)
  ) u_core (
    .clk           (clk),
    .item_valid    (item_valid),
    .item          (item),
    .item_addr     (item_addr),
    .centre        (centre),
    .right         (right),
    .up            (up),
    .older_wr_en   (older_wr_en),
    .older_wr_addr (older_wr_addr),
    .older_wr_data (older_wr_data),
    .push          (push),
    .push_data     (push_data)
  );

  // result queue
  shp3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head),
    .count     (q_count)
  );

  assign pixel_out  = head.pixel;
  assign frame_last = head.last;

endmodule

`default_nettype wire

FILE: test/sharpen_3x3_stream_check.sv
// monitor for the sharpen stream: models the 3x3 filter and checks each result word
module sharpen_3x3_stream_check #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  pixel_out,
  input  logic        frame_last,
  output int          mismatches,
  output int          pending,
  output int          words_checked
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int MAX_HEIGHT = 65535;

  // register contents as written, saturation applied on use
  logic [11:0] width_reg;
  logic [15:0] height_reg;
  logic [2:0]  chans_reg;

  // upper line: row r-2 ahead of the cursor, row r-1 behind it
  // middle line: row r-1 ahead of the cursor, row r behind it
  logic [7:0] upper_line  [LINE_DEPTH];
  logic [7:0] middle_line [LINE_DEPTH];
  int unsigned row_at;
  int unsigned pos_at;

  // sharpened words still owed by the block, oldest first
  shp3_pkg::result_t sharpened_due [$];
  shp3_pkg::result_t due_word;

  function automatic int unsigned saturate(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one input word: update the line stores and queue the word it releases
  task automatic predict_sharpened(input logic [7:0] x);
    int unsigned w, h, c, len, col, p, r;
    int centre, acc;
    shp3_pkg::result_t word;
    w = saturate(32'(width_reg), 3, MAX_WIDTH);
    h = saturate(32'(height_reg), 3, MAX_HEIGHT);
    c = saturate(32'(chans_reg), 1, MAX_CHANNELS);
    len = w * c;
    p = pos_at;
    r = row_at;
    col = p / c;
    centre = int'(middle_line[p]);
    acc = 0;
    // interior pixel of row r-1: left neighbour already moved up, right one not yet
    if (r >= 2 && col >= 1 && col <= w - 2) begin
      acc = 5 * centre - int'(upper_line[p - c]) - int'(middle_line[p + c])
            - int'(upper_line[p]) - int'(x);
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
    end
    word.pixel = 8'(acc);
    word.last  = (r >= h - 1) && (p >= len - 1);
    upper_line[p]  = middle_line[p];
    middle_line[p] = x;
    // cursor wraps once it reaches or passes the end of the row or frame
    if (p >= len - 1) begin
      pos_at = 0;
      row_at = (r >= h - 1) ? 0 : r + 1;
    end else begin
      pos_at = p + 1;
    end
    if (r >= 1) sharpened_due.push_back(word);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = shp3_pkg::RESET_IMAGE_WIDTH;
      height_reg = shp3_pkg::RESET_IMAGE_HEIGHT;
      chans_reg  = shp3_pkg::RESET_CHANNEL_COUNT;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      row_at = 0;
      pos_at = 0;
      sharpened_due.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          shp3_pkg::REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[11:0];
          end
          shp3_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data;
          end
          shp3_pkg::REG_CHANNEL_COUNT: begin
            chans_reg = cfg_data[2:0];
          end
          default: begin
          end
        endcase
      end
      // input words
      if (in_valid && !in_stall) predict_sharpened(sample);
      // result words against the oldest owed one
      if (out_valid && !out_stall) begin
        words_checked++;
        if (sharpened_due.size() == 0) begin
          mismatches++;
          $error("unexpected result word: pixel_out %0d frame_last %0b", pixel_out,
                 frame_last);
        end else begin
          due_word = sharpened_due.pop_front();
          if (pixel_out !== due_word.pixel) begin
            mismatches++;
            $error("pixel_out: expected %0d, got %0d", due_word.pixel, pixel_out);
          end
          if (frame_last !== due_word.last) begin
            mismatches++;
            $error("frame_last: expected %0b, got %0b", due_word.last, frame_last);
          end
        end
      end
    end
    pending = sharpened_due.size();
  end

endmodule

FILE: test/tb_sharpen_3x3_stream.sv
// top of the sharpen stream bench: clock, reset, word and register stimulus, verdict
module tb_sharpen_3x3_stream;
  import shp3_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int MAX_CH       = 4;
  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_WORDS = 480;

  typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_EXTREME} texture_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  pixel_out;
  logic        frame_last;

  int mismatches, pending, words_checked;
  int words_sent, frames_sent, cfg_writes, random_words, idle_cycles;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  sharpen_3x3_stream #(
    .MAX_WIDTH(MAX_W),
    .MAX_CHANNELS(MAX_CH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_out(pixel_out),
    .frame_last(frame_last)
  );

  sharpen_3x3_stream_check #(
    .MAX_WIDTH(MAX_W),
    .MAX_CHANNELS(MAX_CH)
  ) u_sharpen_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_out(pixel_out),
    .frame_last(frame_last),
    .mismatches(mismatches),
    .pending(pending),
    .words_checked(words_checked)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle stretch: mostly short, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3);
  endfunction

  // next sample byte of a frame
  function automatic logic [7:0] texel(input texture_e tex, input int base);
    case (tex)
      TEX_SMOOTH: begin
        return 8'(base + $urandom_range(0, 24) - 12);
      end
      TEX_EXTREME: begin
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // words per frame after the block's saturation of the registers
  function automatic int frame_size(input logic [15:0] w, input logic [15:0] h,
                                    input logic [15:0] c);
    int ew, eh, ec;
    ew = int'(w[11:0]);
    eh = int'(h);
    ec = int'(c[2:0]);
    if (ew < 3) ew = 3;
    if (ew > MAX_W) ew = MAX_W;
    if (eh < 3) eh = 3;
    if (ec < 1) ec = 1;
    if (ec > MAX_CH) ec = MAX_CH;
    return ew * eh * ec;
  endfunction

  // offer one word and hold it until taken; valid is left high unless a gap follows
  task automatic send_word(input logic [7:0] v);
    sample   <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (!quiet && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_words(input int n, input texture_e tex);
    int base;
    base = $urandom_range(20, 235);
    repeat (n) send_word(texel(tex, base));
  endtask

  // one register write; valid stays high for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  task automatic program_frame(input logic [15:0] w, input logic [15:0] h,
                               input logic [15:0] c);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, c);
    cfg_valid <= 1'b0;
  endtask

  // wait until every owed result has come out, then past the pipeline
  task automatic drain();
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_frames(input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] c, input int frames, input texture_e tex);
    program_frame(w, h, c);
    repeat (frames) begin
      send_words(frame_size(w, h, c), tex);
      frames_sent++;
    end
    in_valid <= 1'b0;
    drain();
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no word or write moved
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_sharpen_3x3_stream: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] w, h, c;
    int n;
    texture_e tex;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // registers below range with junk in the upper data bits: a 3x3 single-channel frame
    program_frame(16'hF001, 16'd1, 16'hFFF8);
    // bright centre on black clips high, dark centre on white clips low
    for (int i = 0; i < 9; i++) send_word((i == 4) ? 8'hFF : 8'h00);
    for (int i = 0; i < 9; i++) send_word((i == 4) ? 8'h00 : 8'hFF);
    in_valid <= 1'b0;
    frames_sent += 2;
    drain();

    // width shrinks while the cursor is already past the new row end
    program_frame(16'd5, 16'd5, 16'd2);
    send_words(28, TEX_NOISE);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    cfg_valid <= 1'b0;
    send_words(4, TEX_SMOOTH);
    in_valid <= 1'b0;
    drain();
    // height drops below the current row, which then closes the frame
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    cfg_valid <= 1'b0;
    send_words(3, TEX_SMOOTH);
    in_valid <= 1'b0;
    frames_sent++;
    drain();

    // long output hold-off while words keep coming
    hold_req <= 1'b1;
    run_frames(16'd10, 16'd4, 16'd3, 1, TEX_NOISE);
    random_words += frame_size(16'd10, 16'd4, 16'd3);

    // four channels, words back to back with no idling on either side
    quiet <= 1'b1;
    run_frames(16'd6, 16'd4, 16'd4, 1, TEX_NOISE);
    random_words += frame_size(16'd6, 16'd4, 16'd4);
    quiet <= 1'b0;

    // random small frames, now and then with out-of-range registers
    while (random_words < RANDOM_WORDS) begin
      w = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom_range(3, 7));
      w = w | (16'($urandom_range(0, 15)) << 12);
      h = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom_range(3, 5));
      if ($urandom_range(0, 9) == 0) begin
        c = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(5, 7));
      end else begin
        c = 16'($urandom_range(1, 4));
      end
      c = c | (16'($urandom_range(0, 8191)) << 3);
      n = $urandom_range(1, 2);
      tex = texture_e'($urandom_range(0, 2));
      run_frames(w, h, c, n, tex);
      random_words += n * frame_size(w, h, c);
    end

    @(negedge clk);
    if (pending != 0) $error("%0d result words never arrived", pending);
    $display("covered %0d frames, %0d words in, %0d results checked, %0d register writes",
             frames_sent, words_sent, words_checked, cfg_writes);
    $display("incl. saturated registers, mid-frame width/height cuts, %0d-cycle hold-off",
             LONG_HOLD);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_sharpen_3x3_stream: done, clean");
    end else begin
      $display("tb_sharpen_3x3_stream: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/shp3_pkg.sv
sv/shp3_ram.sv
sv/shp3_front.sv
sv/shp3_core.sv
sv/shp3_queue.sv
sv/sharpen_3x3_stream.sv
test/sharpen_3x3_stream_check.sv
test/tb_sharpen_3x3_stream.sv
